[rtl/srec_pkg.sv]
// Shared types and constants for the S-record framer.
// Item and result payloads, queue command format, op and kind codes.
// No dependencies.
package srec_pkg;

    localparam int BYTE_W     = 8;
    localparam int ADDR_W     = 16;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEN_W-1:0]  RESET_RECORD_SIZE = 6'd34;
    localparam logic [BYTE_W-1:0] FRAME_OVERHEAD    = 8'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_ADDRESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEC_ADDRESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXEC_GIVEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE     = 3'd4;

    typedef enum logic [1:0] {
        OP_DATA   = 2'd0,
        OP_ORIGIN = 2'd1,
        OP_END    = 2'd2,
        OP_FINISH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_S1    = 2'd0,
        KIND_S9    = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef struct packed {
        op_t               operation;
        logic [BYTE_W-1:0] data_byte;
        logic [ADDR_W-1:0] address_value;
        logic              has_entry;
    } item_t;

    typedef struct packed {
        kind_t             record_kind;
        logic [BYTE_W-1:0] byte_value;
        logic              record_end;
        logic              last;
    } result_t;

    // one queued frame job: S1 data record, S9 start record or error marker
    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic              bank;
        logic              last;
    } cmd_t;

    // back end hands a buffer bank back to the front end
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

endpackage

[rtl/srec_record_framer_top.sv]
// Top level of the binary S-record framer: front end, command queue,
// back end and the two-bank record buffer.
// Depends on srec_pkg, srec_front, srec_cmd_fifo, srec_back, srec_ram.
//
//  channel   direction  handshake              payload
//  item      in         item_valid/item_stall  item_data (item_t)
//  result    out        result_valid/stall     result_data (result_t)
//  cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A data byte is taken whenever item_valid is high and item_stall low. A
// record of n data bytes takes n+4 result bytes, an S9 record 4; the back
// end's byte sequencer sets the sustained rate. The item side stalls while a start
// record waits behind its flush, while the two-entry queue is full, or while
// a byte would land in the buffer bank that is still being sent.
// Reset is immediate; the buffer needs no clearing pass. cfg_ready is always high.
module srec_record_framer_top
    import srec_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = 56
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item_data,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W  = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
    localparam int RAM_AW = IDX_W + 1;

    logic              fifo_full;
    logic              fifo_empty;
    logic              push_valid;
    cmd_t              push_cmd;
    cmd_t              head;
    logic              pop;
    bank_release_t     bank_release;
    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [RAM_AW-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;

    srec_front #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fifo_full    (fifo_full),
        .push_valid   (push_valid),
        .push_cmd     (push_cmd),
        .bank_release (bank_release),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    srec_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    srec_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(2 ** RAM_AW)
    ) u_buffer (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    srec_back #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .fifo_empty   (fifo_empty),
        .head         (head),
        .pop          (pop),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .bank_release (bank_release),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

[rtl/srec_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/srec_cmd_fifo.sv]
// Two-entry command queue between the framer front and back ends.
// Depends on srec_pkg (cmd_t).
module srec_cmd_fifo
    import srec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("command pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("command popped from empty queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count did not follow push");

endmodule

[rtl/srec_front.sv]
// Front end: takes item transactions and config writes, keeps fill count and
// addresses, writes data bytes into the bank buffer and queues frame jobs.
// Depends on srec_pkg.
module srec_front
    import srec_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = 56
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   fifo_full,
    output logic                   push_valid,
    output cmd_t                   push_cmd,
    input  bank_release_t          bank_release,
    output logic                   wr_en,
    output logic [((MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1):0] wr_addr,
    output logic [BYTE_W-1:0]      wr_data
);

    localparam int IDX_W = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_RECORD_BYTES);

    logic [LEN_W-1:0]  size_reg;
    logic [ADDR_W-1:0] exec_addr_reg;
    logic              override_reg;
    logic [LEN_W-1:0]  fill_reg;
    logic [ADDR_W-1:0] rec_addr_reg;
    logic              end_seen_reg;
    logic              exec_known_reg;
    logic              bank_reg;
    logic [1:0]        busy_reg;
    logic              pend_reg;
    cmd_t              pend_cmd_reg;

    logic [LEN_W-1:0] eff_size;
    logic             has_fill;
    logic             full_rec;
    logic             tgt_bank;
    logic             blocked;
    logic             accept;
    logic             first_valid;
    logic             second_valid;
    cmd_t             first_cmd;
    cmd_t             second_cmd;
    cmd_t             frame_cmd;
    cmd_t             s9_cmd;
    logic             flush_now;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = LEN_W'(1);
        end
        else if (size_reg > MAX_LEN)
        begin
            eff_size = MAX_LEN;
        end
        else
        begin
            eff_size = size_reg;
        end
    end

    assign has_fill = (fill_reg != '0);
    assign full_rec = (fill_reg >= eff_size);

    always_comb
    begin
        frame_cmd      = '{kind: KIND_S1, addr: rec_addr_reg, len: fill_reg,
                           bank: bank_reg, last: 1'b1};
        s9_cmd         = '{kind: KIND_S9, addr: exec_addr_reg, len: '0,
                           bank: 1'b0, last: 1'b1};
        first_cmd      = frame_cmd;
        second_cmd     = s9_cmd;
        first_valid    = 1'b0;
        second_valid   = 1'b0;
        tgt_bank       = bank_reg;
        blocked        = 1'b0;
        case (item_data.operation)
            OP_DATA:
            begin
                tgt_bank    = full_rec ? ~bank_reg : bank_reg;
                blocked     = busy_reg[tgt_bank];
                first_valid = full_rec;
            end
            OP_ORIGIN:
            begin
                first_valid = has_fill;
            end
            OP_END:
            begin
                if (override_reg == 1'b0)
                begin
                    second_cmd.addr = item_data.address_value;
                end
                if (end_seen_reg)
                begin
                    first_valid = 1'b1;
                    first_cmd   = '{kind: KIND_ERROR, addr: '0, len: '0,
                                    bank: 1'b0, last: 1'b1};
                end
                else if (has_fill)
                begin
                    first_valid    = 1'b1;
                    first_cmd.last = ~item_data.has_entry;
                    second_valid   = item_data.has_entry;
                end
                else
                begin
                    first_valid = item_data.has_entry;
                    first_cmd   = second_cmd;
                end
            end
            OP_FINISH:
            begin
                if (!end_seen_reg)
                begin
                    if (has_fill)
                    begin
                        first_valid    = 1'b1;
                        first_cmd.last = ~exec_known_reg;
                        second_valid   = exec_known_reg;
                    end
                    else
                    begin
                        first_valid = exec_known_reg;
                        first_cmd   = s9_cmd;
                    end
                end
            end
            default:
            begin
                first_valid = 1'b0;
            end
        endcase
    end

    assign item_stall = pend_reg || fifo_full || blocked;
    assign accept     = item_valid && !item_stall;
    assign push_valid = pend_reg ? !fifo_full : (accept && first_valid);
    assign push_cmd   = pend_reg ? pend_cmd_reg : first_cmd;
    assign flush_now  = accept && first_valid && (first_cmd.kind == KIND_S1);

    assign wr_en   = accept && (item_data.operation == OP_DATA);
    assign wr_addr = {tgt_bank, full_rec ? IDX_W'(0) : fill_reg[IDX_W-1:0]};
    assign wr_data = item_data.data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg       <= RESET_RECORD_SIZE;
            exec_addr_reg  <= '0;
            override_reg   <= 1'b0;
            fill_reg       <= '0;
            rec_addr_reg   <= '0;
            end_seen_reg   <= 1'b0;
            exec_known_reg <= 1'b0;
            bank_reg       <= 1'b0;
            busy_reg       <= '0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                case (item_data.operation)
                    OP_DATA:
                    begin
                        if (full_rec)
                        begin
                            rec_addr_reg <= rec_addr_reg + ADDR_W'(fill_reg);
                            fill_reg     <= LEN_W'(1);
                        end
                        else
                        begin
                            fill_reg <= fill_reg + LEN_W'(1);
                        end
                    end
                    OP_ORIGIN:
                    begin
                        fill_reg <= '0;
                        if (!override_reg)
                        begin
                            rec_addr_reg <= item_data.address_value;
                        end
                    end
                    OP_END:
                    begin
                        if (!end_seen_reg)
                        begin
                            fill_reg       <= '0;
                            end_seen_reg   <= 1'b1;
                            exec_known_reg <= 1'b1;
                        end
                    end
                    OP_FINISH:
                    begin
                        if (!end_seen_reg)
                        begin
                            fill_reg <= '0;
                        end
                    end
                    default:
                    begin
                        fill_reg <= fill_reg;
                    end
                endcase
            end

            // each flush hands the current bank to the back end
            if (flush_now)
            begin
                bank_reg           <= ~bank_reg;
                busy_reg[bank_reg] <= 1'b1;
            end
            if (bank_release.valid)
            begin
                busy_reg[bank_release.bank] <= 1'b0;
            end

            if (accept && second_valid)
            begin
                pend_reg <= 1'b1;
            end
            else if (pend_reg && !fifo_full)
            begin
                pend_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RECORD_SIZE:  size_reg       <= cfg_data[LEN_W-1:0];
                    CFG_LOAD_ADDRESS: rec_addr_reg   <= cfg_data[ADDR_W-1:0];
                    CFG_EXEC_ADDRESS: exec_addr_reg  <= cfg_data[ADDR_W-1:0];
                    CFG_EXEC_GIVEN:   exec_known_reg <= cfg_data[0];
                    CFG_OVERRIDE:     override_reg   <= cfg_data[0];
                    default:          override_reg   <= override_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && second_valid)
        begin
            pend_cmd_reg <= second_cmd;
        end
    end

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !busy_reg[wr_addr[IDX_W]])
        else $error("data byte written into bank still being framed");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= MAX_LEN)
        else $error("fill count above buffer depth");
    a_pend_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && second_valid) |=> (pend_reg && (pend_cmd_reg.kind == KIND_S9)))
        else $error("start record not held after flush");

endmodule

[rtl/srec_back.sv]
// Back end: pops frame jobs and emits count, address, data and checksum
// bytes, or an error marker, through a registered result port. Reads data
// from the bank buffer. Depends on srec_pkg.
module srec_back
    import srec_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = 56
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fifo_empty,
    input  cmd_t                head,
    output logic                pop,
    output logic [((MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1):0] rd_addr,
    input  logic [BYTE_W-1:0]   rd_data,
    output bank_release_t       bank_release,
    output logic                result_valid,
    input  logic                result_stall,
    output result_t             result_data
);

    localparam int IDX_W = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR_HI,
        ST_ADDR_LO,
        ST_DATA,
        ST_CSUM
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [BYTE_W-1:0] sum_reg;
    logic              valid_reg;
    result_t           out_reg;

    logic              out_free;
    logic [IDX_W-1:0]  idx_rd;
    logic [BYTE_W-1:0] count_byte;

    assign out_free     = !valid_reg || !result_stall;
    assign pop          = (state_reg == ST_IDLE) && !fifo_empty && out_free;
    assign count_byte   = BYTE_W'(head.len) + FRAME_OVERHEAD;
    assign result_valid = valid_reg;
    assign result_data  = out_reg;

    // read address runs with the index so read data is ready on each step
    always_comb
    begin
        idx_rd = idx_reg;
        if (out_free && (state_reg == ST_ADDR_LO))
        begin
            idx_rd = '0;
        end
        else if (out_free && (state_reg == ST_DATA))
        begin
            idx_rd = idx_reg + IDX_W'(1);
        end
    end

    assign rd_addr = {cmd_reg.bank, idx_rd};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cmd_reg      <= '0;
            idx_reg      <= '0;
            sum_reg      <= '0;
            valid_reg    <= 1'b0;
            out_reg      <= '0;
            bank_release <= '0;
        end
        else
        begin
            bank_release.valid <= 1'b0;
            if (out_free)
            begin
                valid_reg <= 1'b0;
                idx_reg   <= idx_rd;
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (!fifo_empty)
                        begin
                            cmd_reg   <= head;
                            valid_reg <= 1'b1;
                            if (head.kind == KIND_ERROR)
                            begin
                                out_reg <= '{record_kind: KIND_ERROR, byte_value: '0,
                                             record_end: 1'b1, last: head.last};
                            end
                            else
                            begin
                                out_reg   <= '{record_kind: head.kind, byte_value: count_byte,
                                               record_end: 1'b0, last: 1'b0};
                                sum_reg   <= count_byte;
                                state_reg <= ST_ADDR_HI;
                            end
                        end
                    end
                    ST_ADDR_HI:
                    begin
                        valid_reg          <= 1'b1;
                        out_reg.byte_value <= cmd_reg.addr[15:8];
                        sum_reg            <= sum_reg + cmd_reg.addr[15:8];
                        state_reg          <= ST_ADDR_LO;
                    end
                    ST_ADDR_LO:
                    begin
                        valid_reg          <= 1'b1;
                        out_reg.byte_value <= cmd_reg.addr[7:0];
                        sum_reg            <= sum_reg + cmd_reg.addr[7:0];
                        state_reg          <= (cmd_reg.len == '0) ? ST_CSUM : ST_DATA;
                    end
                    ST_DATA:
                    begin
                        valid_reg          <= 1'b1;
                        out_reg.byte_value <= rd_data;
                        sum_reg            <= sum_reg + rd_data;
                        if (LEN_W'(idx_reg) == (cmd_reg.len - LEN_W'(1)))
                        begin
                            state_reg <= ST_CSUM;
                        end
                    end
                    ST_CSUM:
                    begin
                        valid_reg          <= 1'b1;
                        out_reg.byte_value <= ~sum_reg;
                        out_reg.record_end <= 1'b1;
                        out_reg.last       <= cmd_reg.last;
                        bank_release.valid <= (cmd_reg.kind == KIND_S1);
                        bank_release.bank  <= cmd_reg.bank;
                        state_reg          <= ST_IDLE;
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

endmodule
